[design/rgbled_pkg.sv]
// Shared types, codes and reset constants for the RGB LED serial pulse driver.
package rgbled_pkg;

	localparam int unsigned FRAME_BITS_DEF  = 24;
	localparam int unsigned COUNT_WIDTH_DEF = 16;

	localparam int unsigned COLOR_W = 24;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd2;

	// Configuration reset values
	localparam logic [CFG_W-1:0] ZERO_HIGH_RST  = 16'd26;
	localparam logic [CFG_W-1:0] ONE_HIGH_RST   = 16'd52;
	localparam logic [CFG_W-1:0] BIT_PERIOD_RST = 16'd81;

	localparam logic [COLOR_W-1:0] LAST_SENT_RST = 24'hFFFFFF;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_SET_ALL   = 3'd1,
		OP_SET_RED   = 3'd2,
		OP_SET_GREEN = 3'd3,
		OP_SET_BLUE  = 3'd4,
		OP_ON        = 3'd5,
		OP_OFF       = 3'd6
	} opcode_t;

	typedef struct packed {
		logic               data_line;
		logic               lock_line;
		logic               busy_res;
		logic               is_on;
		logic [COLOR_W-1:0] packed_color;
	} result_t;

	typedef struct packed {
		logic push;   // request taken this cycle
		logic ready;  // buffer can take a request
	} hs_t;

endpackage

[design/rgbled_cmd_if.sv]
// Command channel: opcode and color values, valid/ready.
interface rgbled_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] red_value;
	logic [7:0] green_value;
	logic [7:0] blue_value;

	modport source (output valid, output opcode, output red_value, output green_value,
		output blue_value, input ready);
	modport sink (input valid, input opcode, input red_value, input green_value,
		input blue_value, output ready);
endinterface

[design/rgbled_res_if.sv]
// Result channel: line levels and status, valid/ready.
interface rgbled_res_if;
	logic        valid;
	logic        ready;
	logic        data_line;
	logic        lock_line;
	logic        busy_res;
	logic        is_on;
	logic [23:0] packed_color;

	modport source (output valid, output data_line, output lock_line, output busy_res,
		output is_on, output packed_color, input ready);
	modport sink (input valid, input data_line, input lock_line, input busy_res,
		input is_on, input packed_color, output ready);
endinterface

[design/rgbled_cfg_if.sv]
// Configuration write channel: register index and data, valid/ready.
interface rgbled_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rgbled_pkg::CFG_IDX_W-1:0] index;
	logic [rgbled_pkg::CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/rgbled_engine.sv]
// Color/frame state, pulse timing and per-request result logic.
module rgbled_engine #(
	parameter int unsigned FRAME_BITS  = rgbled_pkg::FRAME_BITS_DEF,
	parameter int unsigned COUNT_WIDTH = rgbled_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rgbled_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgbled_pkg::CFG_W-1:0]     cfg_data,
	input  rgbled_pkg::hs_t                 hs,
	input  logic [2:0]                      opcode,
	input  logic [7:0]                      red_value,
	input  logic [7:0]                      green_value,
	input  logic [7:0]                      blue_value,
	output rgbled_pkg::result_t             result
);
	localparam int unsigned BIDX_W = $clog2(FRAME_BITS);
	localparam int unsigned EXT_W  = (COUNT_WIDTH > rgbled_pkg::CFG_W) ? COUNT_WIDTH
		: rgbled_pkg::CFG_W;
	localparam int unsigned CW = rgbled_pkg::COLOR_W;

	logic [rgbled_pkg::CFG_W-1:0] zero_high_q, one_high_q, bit_period_q;
	logic [7:0]          red_q, green_q, blue_q;
	logic                enabled_q;
	logic [CW-1:0]       last_sent_q;
	logic [CW-1:0]       shift_q;
	logic [BIDX_W-1:0]   bidx_q;
	logic [COUNT_WIDTH-1:0] slot_q;
	logic                in_frame_q;

	logic [7:0]          red_n, green_n, blue_n;
	logic                enabled_n;
	logic [CW-1:0]       disp;
	logic                differs, start, active;
	logic [CW-1:0]       shift_e;
	logic [BIDX_W-1:0]   bidx_e;
	logic [COUNT_WIDTH-1:0] slot_e;
	logic [EXT_W-1:0]    zero_ext, one_ext, period_ext;
	logic [COUNT_WIDTH-1:0] high_m, period_m;
	logic [COUNT_WIDTH:0] slot_inc;
	logic                slot_end, frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q  <= rgbled_pkg::ZERO_HIGH_RST;
			one_high_q   <= rgbled_pkg::ONE_HIGH_RST;
			bit_period_q <= rgbled_pkg::BIT_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rgbled_pkg::CFG_ZERO_HIGH:  zero_high_q  <= cfg_data;
				rgbled_pkg::CFG_ONE_HIGH:   one_high_q   <= cfg_data;
				rgbled_pkg::CFG_BIT_PERIOD: bit_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Command decode
	always_comb begin
		red_n     = red_q;
		green_n   = green_q;
		blue_n    = blue_q;
		enabled_n = enabled_q;
		case (rgbled_pkg::opcode_t'(opcode))
			rgbled_pkg::OP_SET_ALL: begin
				red_n   = red_value;
				green_n = green_value;
				blue_n  = blue_value;
			end
			rgbled_pkg::OP_SET_RED:   red_n     = red_value;
			rgbled_pkg::OP_SET_GREEN: green_n   = green_value;
			rgbled_pkg::OP_SET_BLUE:  blue_n    = blue_value;
			rgbled_pkg::OP_ON:        enabled_n = 1'b1;
			rgbled_pkg::OP_OFF:       enabled_n = 1'b0;
			default: ;
		endcase
	end

	assign disp    = enabled_n ? {green_n, red_n, blue_n} : '0;
	assign differs = (disp != last_sent_q);
	assign start   = !in_frame_q && differs;
	assign active  = in_frame_q || start;
	assign shift_e = start ? disp : shift_q;
	assign bidx_e  = start ? '0 : bidx_q;
	assign slot_e  = start ? '0 : slot_q;

	assign zero_ext   = EXT_W'(zero_high_q);
	assign one_ext    = EXT_W'(one_high_q);
	assign period_ext = EXT_W'(bit_period_q);
	assign high_m     = shift_e[CW-1] ? one_ext[COUNT_WIDTH-1:0] : zero_ext[COUNT_WIDTH-1:0];
	assign period_m   = period_ext[COUNT_WIDTH-1:0];

	assign slot_inc  = {1'b0, slot_e} + 1'b1;
	assign slot_end  = (slot_inc >= {1'b0, period_m});
	assign frame_end = (bidx_e == BIDX_W'(FRAME_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
			enabled_q   <= 1'b1;
			last_sent_q <= rgbled_pkg::LAST_SENT_RST;
			shift_q     <= '0;
			bidx_q      <= '0;
			slot_q      <= '0;
			in_frame_q  <= 1'b0;
		end else if (hs.push) begin
			red_q     <= red_n;
			green_q   <= green_n;
			blue_q    <= blue_n;
			enabled_q <= enabled_n;
			if (start) begin
				last_sent_q <= disp;
			end
			if (active) begin
				if (slot_end) begin
					slot_q  <= '0;
					shift_q <= {shift_e[CW-2:0], 1'b0};
					if (frame_end) begin
						bidx_q     <= '0;
						in_frame_q <= 1'b0;
					end else begin
						bidx_q     <= bidx_e + 1'b1;
						in_frame_q <= 1'b1;
					end
				end else begin
					slot_q     <= slot_inc[COUNT_WIDTH-1:0];
					shift_q    <= shift_e;
					bidx_q     <= bidx_e;
					in_frame_q <= 1'b1;
				end
			end
		end
	end

	assign result.data_line    = active ? (slot_e < high_m) : 1'b1;
	assign result.lock_line    = active;
	assign result.busy_res     = active || differs;
	assign result.is_on        = enabled_n;
	assign result.packed_color = {blue_n, green_n, red_n};
endmodule

[design/rgbled_outbuf.sv]
// Two-entry result buffer: output register plus skid register.
module rgbled_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rgbled_pkg::result_t din,
	output rgbled_pkg::hs_t     hs_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output rgbled_pkg::result_t dout
);
	rgbled_pkg::result_t main_q, skid_q;
	logic main_v_q, skid_v_q;
	logic pop;

	assign pop            = main_v_q && out_ready;
	assign hs_ready.ready = !skid_v_q;
	assign hs_ready.push  = push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= din;
			end else begin
				main_q <= din;
			end
		end
	end

	assign out_valid = main_v_q;
	assign dout      = main_q;
endmodule

[design/rgb_led_serial_pulse_driver_core.sv]
// Top level of the RGB LED serial pulse driver (single-wire GRB transmitter).
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------------
//  cmd     | in  | valid/ready      | opcode, red_value, green_value, blue_value
//  res     | out | valid/ready      | data_line, lock_line, busy_res, is_on, packed_color
//  cfg     | in  | valid/ready(=1)  | index, data
//
//  One request (one pulse-timer tick) is taken per cycle while cmd.ready is high and
//  yields one result from the engine's single-pass logic, registered into the output
//  register, or into the skid register while it is held. The two-entry buffer keeps
//  cmd.ready high while one result waits; cmd.ready drops only when both are full.
//  arst_n clears colors to black, turns the LED on and marks the last sent color
//  as all ones, so the first tick after reset starts a black frame.
module rgb_led_serial_pulse_driver_core #(
	parameter int unsigned FRAME_BITS  = rgbled_pkg::FRAME_BITS_DEF,
	parameter int unsigned COUNT_WIDTH = rgbled_pkg::COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rgbled_cmd_if.sink   cmd,
	rgbled_res_if.source res,
	rgbled_cfg_if.sink   cfg
);
	rgbled_pkg::hs_t     hs;
	rgbled_pkg::result_t eng_result;
	rgbled_pkg::result_t buf_result;
	logic                push;
	logic                buf_valid;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	// A request is taken whenever the skid entry is free.
	assign cmd.ready = hs.ready;
	assign push      = cmd.valid && hs.ready;

	rgbled_engine #(
		.FRAME_BITS  (FRAME_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.hs          (hs),
		.opcode      (cmd.opcode),
		.red_value   (cmd.red_value),
		.green_value (cmd.green_value),
		.blue_value  (cmd.blue_value),
		.result      (eng_result)
	);

	rgbled_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (eng_result),
		.hs_ready  (hs),
		.out_valid (buf_valid),
		.out_ready (res.ready),
		.dout      (buf_result)
	);

	assign res.valid        = buf_valid;
	assign res.data_line    = buf_result.data_line;
	assign res.lock_line    = buf_result.lock_line;
	assign res.busy_res     = buf_result.busy_res;
	assign res.is_on        = buf_result.is_on;
	assign res.packed_color = buf_result.packed_color;
endmodule
